### design/regular_grid_table_interpolator_macros.svh
// assertion macros for the regular grid table interpolator
`ifndef REGULAR_GRID_TABLE_INTERPOLATOR_MACROS_SVH
`define REGULAR_GRID_TABLE_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define RGTI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgti check failed");
`define RGTI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgti check failed");
`else
`define RGTI_ASSERT_SAME(label, clk, rst, ante, cons)
`define RGTI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/rgti_pkg.sv
// shared constants for the regular grid table interpolator
package rgti_pkg;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned COORD_W  = 24;
   localparam int unsigned ADDR_W   = 16;
   localparam int unsigned DEPTH    = 65536;
   localparam int unsigned IDX_W    = 8;
   localparam int unsigned FRAC_W   = 17;
   localparam int unsigned CSR_IDX_W = 3;

   localparam int unsigned DEF_GRID_Z   = 8;
   localparam int unsigned DEF_GRID_M   = 32;
   localparam int unsigned DEF_GRID_AGE = 32;

   localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'd65536;
   localparam logic [FRAC_W-1:0] FRAC_HALF = 17'd32768;

   localparam logic [1:0] KIND_WRITE     = 2'd0;
   localparam logic [1:0] KIND_TRILINEAR = 2'd1;
   localparam logic [1:0] KIND_BILINEAR  = 2'd2;
   localparam logic [1:0] KIND_NEAREST   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_Z_ORIGIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_INV_STEP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_M_ORIGIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_M_INV_STEP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_ORIGIN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_INV_STEP = 3'd5;

   localparam logic [23:0] INV_STEP_RESET = 24'd65536;
endpackage

### design/regular_grid_table_interpolator.sv
// regular grid table interpolator: table store, axis mapping and blending sequencer
// A write word (kind 0) is stored in the cycle it is accepted and busy stays low.
// A query runs on one shared multiplier: three multiply/capture pairs map the axes,
// the corners are read one per cycle from the single read port of the store
// (8, 4 or 1 reads, plus a drain state for the last read), then each blend takes a
// multiply state and an add state (7, 3 or 0 blends), and a done state hands the word
// out. Busy stays high for the whole query; the result strobe rsp_valid is high for
// one cycle just after busy falls and cannot be stalled.
`include "regular_grid_table_interpolator_macros.svh"
module regular_grid_table_interpolator #(
   parameter int unsigned GRID_Z   = rgti_pkg::DEF_GRID_Z,
   parameter int unsigned GRID_M   = rgti_pkg::DEF_GRID_M,
   parameter int unsigned GRID_AGE = rgti_pkg::DEF_GRID_AGE
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_kind,
   input  logic [2:0]                         req_table_select,
   input  logic signed [rgti_pkg::COORD_W-1:0] req_coord_z,
   input  logic signed [rgti_pkg::COORD_W-1:0] req_coord_m,
   input  logic signed [rgti_pkg::COORD_W-1:0] req_coord_age,
   input  logic [rgti_pkg::ADDR_W-1:0]        req_write_address,
   input  logic signed [rgti_pkg::WORD_W-1:0] req_write_word,
   output logic                               rsp_valid,
   output logic signed [rgti_pkg::WORD_W-1:0] rsp_value,
   input  logic                               csr_write_enable,
   input  logic [rgti_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rgti_pkg::COORD_W-1:0]       csr_write_data
);
   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_MAP_MUL  = 8'b0000_0010,
      ST_MAP_CAP  = 8'b0000_0100,
      ST_READ     = 8'b0000_1000,
      ST_DRAIN    = 8'b0001_0000,
      ST_LERP_MUL = 8'b0010_0000,
      ST_LERP_ADD = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   localparam int unsigned IW = rgti_pkg::IDX_W;
   localparam int unsigned FW = rgti_pkg::FRAC_W;
   localparam logic [15:0] Z_LAST   = 16'(GRID_Z - 1);
   localparam logic [15:0] M_LAST   = 16'(GRID_M - 1);
   localparam logic [15:0] AGE_LAST = 16'(GRID_AGE - 1);
   localparam logic [IW-1:0] Z_CELL   = IW'(GRID_Z - 2);
   localparam logic [IW-1:0] M_CELL   = IW'(GRID_M - 2);
   localparam logic [IW-1:0] AGE_CELL = IW'(GRID_AGE - 2);

   state_type state_ff, state_in;

   logic signed [23:0] z_origin_ff, m_origin_ff, age_origin_ff;
   logic [23:0]        z_inv_ff, m_inv_ff, age_inv_ff;

   logic [1:0]         kind_ff;
   logic [2:0]         table_ff;
   logic signed [23:0] cz_ff, cm_ff, ca_ff;

   logic [1:0]    axis_ff, axis_in;
   logic [IW-1:0] idx_z_ff, idx_m_ff, idx_a_ff;
   logic [FW-1:0] frac_z_ff, frac_m_ff, frac_a_ff;
   logic [2:0]    rc_ff, rc_in;
   logic [2:0]    step_ff, step_in;
   logic          rd_valid_ff;
   logic [2:0]    rd_slot_ff;
   logic [31:0]   rdata_ff;
   logic signed [31:0] q_ff [8];
   logic signed [58:0] prod_ff;
   logic          rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;

   logic [31:0] mem [rgti_pkg::DEPTH];

   logic accept, wr_en;
   logic signed [23:0] ax_coord, ax_origin;
   logic [23:0]        ax_inv;
   logic signed [24:0] ax_d;
   logic signed [33:0] op_a;
   logic signed [24:0] op_b;
   logic [47:0]        x_val;
   logic [FW-1:0]      lerp_frac;
   logic signed [31:0] lerp_res;
   logic [2:0]    last_rc, last_step;
   logic [3:0]    wpos;
   logic [IW-1:0] cz_idx, cm_idx, ca_idx;
   logic [15:0]   rd_addr;

   function automatic logic [15:0] addr_of(input logic [2:0] t, input logic [IW-1:0] z,
                                           input logic [IW-1:0] m, input logic [IW-1:0] a);
      logic [31:0] v;
      v = ((32'(t) * 32'(GRID_Z) + 32'(z)) * 32'(GRID_M) + 32'(m)) * 32'(GRID_AGE)
          + 32'(a);
      return v[15:0];
   endfunction

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign wr_en  = accept && (req_kind == rgti_pkg::KIND_WRITE);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         z_origin_ff   <= '0;
         m_origin_ff   <= '0;
         age_origin_ff <= '0;
         z_inv_ff      <= rgti_pkg::INV_STEP_RESET;
         m_inv_ff      <= rgti_pkg::INV_STEP_RESET;
         age_inv_ff    <= rgti_pkg::INV_STEP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rgti_pkg::CSR_Z_ORIGIN:     z_origin_ff   <= csr_write_data;
            rgti_pkg::CSR_Z_INV_STEP:   z_inv_ff      <= csr_write_data;
            rgti_pkg::CSR_M_ORIGIN:     m_origin_ff   <= csr_write_data;
            rgti_pkg::CSR_M_INV_STEP:   m_inv_ff      <= csr_write_data;
            rgti_pkg::CSR_AGE_ORIGIN:   age_origin_ff <= csr_write_data;
            rgti_pkg::CSR_AGE_INV_STEP: age_inv_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // axis operand selection
   always_comb begin
      case (axis_ff)
         2'd0: begin
            ax_coord = cz_ff; ax_origin = z_origin_ff; ax_inv = z_inv_ff;
         end
         2'd1: begin
            ax_coord = cm_ff; ax_origin = m_origin_ff; ax_inv = m_inv_ff;
         end
         default: begin
            ax_coord = ca_ff; ax_origin = age_origin_ff; ax_inv = age_inv_ff;
         end
      endcase
      ax_d = 25'(ax_coord) - 25'(ax_origin);
   end

   // blend fraction and result slot
   always_comb begin
      if (kind_ff == rgti_pkg::KIND_TRILINEAR) begin
         last_rc   = 3'd7;
         last_step = 3'd6;
         if (step_ff < 3'd4)      lerp_frac = frac_a_ff;
         else if (step_ff < 3'd6) lerp_frac = frac_m_ff;
         else                     lerp_frac = frac_z_ff;
      end else if (kind_ff == rgti_pkg::KIND_BILINEAR) begin
         last_rc   = 3'd3;
         last_step = 3'd2;
         lerp_frac = (step_ff < 3'd2) ? frac_m_ff : frac_z_ff;
      end else begin
         last_rc   = 3'd0;
         last_step = 3'd0;
         lerp_frac = frac_z_ff;
      end
      wpos = 4'({1'b0, last_rc}) - 4'd1 - 4'(step_ff);
   end

   // shared multiplier operands
   always_comb begin
      if (state_ff == ST_LERP_MUL) begin
         op_a = 34'(q_ff[1]) - 34'(q_ff[0]);
         op_b = 25'({1'b0, lerp_frac});
      end else begin
         op_a = (ax_d > 25'sd0) ? 34'(ax_d) : '0;
         op_b = 25'({1'b0, ax_inv});
      end
   end

   assign x_val    = prod_ff[47:0];
   assign lerp_res = q_ff[0] + prod_ff[47:16];

   // corner address
   always_comb begin
      case (kind_ff)
         rgti_pkg::KIND_TRILINEAR: begin
            cz_idx = idx_z_ff + IW'(rc_ff[2]);
            cm_idx = idx_m_ff + IW'(rc_ff[1]);
            ca_idx = idx_a_ff + IW'(rc_ff[0]);
         end
         rgti_pkg::KIND_BILINEAR: begin
            cz_idx = idx_z_ff + IW'(rc_ff[1]);
            cm_idx = idx_m_ff + IW'(rc_ff[0]);
            ca_idx = '0;
         end
         default: begin
            cz_idx = idx_z_ff + IW'(frac_z_ff > rgti_pkg::FRAC_HALF);
            cm_idx = idx_m_ff + IW'(frac_m_ff > rgti_pkg::FRAC_HALF);
            ca_idx = '0;
         end
      endcase
      rd_addr = addr_of(table_ff, cz_idx, cm_idx, ca_idx);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      rc_in    = rc_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind != rgti_pkg::KIND_WRITE)) begin
               state_in = ST_MAP_MUL;
               axis_in  = 2'd0;
            end
         end
         ST_MAP_MUL: state_in = ST_MAP_CAP;
         ST_MAP_CAP: begin
            if (axis_ff == 2'd2) begin
               state_in = ST_READ;
               rc_in    = '0;
            end else begin
               state_in = ST_MAP_MUL;
               axis_in  = axis_ff + 2'd1;
            end
         end
         ST_READ: begin
            if (rc_ff == last_rc) state_in = ST_DRAIN;
            else                  rc_in    = rc_ff + 3'd1;
         end
         ST_DRAIN: begin
            step_in  = '0;
            state_in = (kind_ff == rgti_pkg::KIND_NEAREST) ? ST_DONE : ST_LERP_MUL;
         end
         ST_LERP_MUL: state_in = ST_LERP_ADD;
         ST_LERP_ADD: begin
            if (step_ff == last_step) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LERP_MUL;
               step_in  = step_ff + 3'd1;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         rc_ff        <= '0;
         step_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rc_ff        <= rc_in;
         step_ff      <= step_in;
         rd_valid_ff  <= (state_ff == ST_READ);
         rsp_valid_ff <= (state_ff == ST_DONE);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff    <= 59'(op_a * op_b);
      rd_slot_ff <= rc_ff;
      if (accept) begin
         kind_ff  <= req_kind;
         table_ff <= req_table_select;
         cz_ff    <= req_coord_z;
         cm_ff    <= req_coord_m;
         ca_ff    <= req_coord_age;
      end
      if (state_ff == ST_MAP_CAP) begin
         case (axis_ff)
            2'd0: begin
               if (x_val[47:32] >= Z_LAST) begin
                  idx_z_ff <= Z_CELL; frac_z_ff <= rgti_pkg::FRAC_ONE;
               end else begin
                  idx_z_ff <= x_val[32 +: IW]; frac_z_ff <= {1'b0, x_val[31:16]};
               end
            end
            2'd1: begin
               if (x_val[47:32] >= M_LAST) begin
                  idx_m_ff <= M_CELL; frac_m_ff <= rgti_pkg::FRAC_ONE;
               end else begin
                  idx_m_ff <= x_val[32 +: IW]; frac_m_ff <= {1'b0, x_val[31:16]};
               end
            end
            default: begin
               if (x_val[47:32] >= AGE_LAST) begin
                  idx_a_ff <= AGE_CELL; frac_a_ff <= rgti_pkg::FRAC_ONE;
               end else begin
                  idx_a_ff <= x_val[32 +: IW]; frac_a_ff <= {1'b0, x_val[31:16]};
               end
            end
         endcase
      end
      if (rd_valid_ff) begin
         q_ff[rd_slot_ff] <= rdata_ff;
      end else if (state_ff == ST_LERP_ADD) begin
         for (int i = 0; i < 8; i++) begin
            if (i == int'(wpos))  q_ff[i] <= lerp_res;
            else if (i < 6)       q_ff[i] <= q_ff[(i + 2) & 7];
         end
      end
      if (state_ff == ST_DONE) rsp_value_ff <= q_ff[0];
   end

   // table store
   always_ff @(posedge clock) begin
      if (wr_en) mem[req_write_address] <= req_write_word;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   `RGTI_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `RGTI_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `RGTI_ASSERT_NEXT(a_query_busy, clock, reset, accept && !wr_en, busy)
   `RGTI_ASSERT_NEXT(a_write_idle, clock, reset, wr_en, !busy && !rsp_valid)
endmodule
